@@ sv/brms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brms_pkg: shared types and constants
// Widths, register indexes and sequencer states of the RMS envelope unit.
// ----------------------------------------------------------------------------
package brms_pkg;

   localparam int FRAME_W     = 25;  // frame counts and bounds
   localparam int COUNT_W     = 7;   // bucket count / index
   localparam int SUM_W       = 55;  // sum of squares, wraps
   localparam int INTERVAL_W  = 32;  // Q16.16 bucket interval
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int LEVEL_W     = 16;
   localparam int NUMBER_W    = 6;

   localparam int DEF_MAX_BUCKETS = 64;
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_FRAME_BITS  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_TOTAL      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TRIM_START = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TRIM_END   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COUNT      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_INTERVAL   = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE_MUL,
      ST_EDGE_RES,
      ST_EDGE_DIV,
      ST_CHECK,
      ST_MEAN,
      ST_ROOT,
      ST_SEND,
      ST_ACC
   } state_type;

endpackage

@@ sv/brms_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brms_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brms_div import brms_pkg::*; #(
   parameter int DIVIDEND_W = SUM_W,
   parameter int DIVISOR_W  = FRAME_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ sv/brms_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brms_sqrt: digit-serial integer square root
// Two radicand bits per cycle, floor result.
// ----------------------------------------------------------------------------
module brms_sqrt import brms_pkg::*; #(
   parameter int RAD_W = SUM_W + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [RAD_W-1:0]   radicand,
   output logic               done,
   output logic [RAD_W/2-1:0] root
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+1:0] shifted;
   logic [ROOT_W+1:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      shifted = {rem_ff[ROOT_W-1:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial   = {root_ff, 2'b01};
      if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ROOT_W);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ sv/bucketed_rms_envelope_unit.sv @@
`timescale 1ns / 1ps
// A word with no work (zero frames or buckets) is taken in the idle state; when
//   all buckets are done it also passes the accumulate state; else two bucket
//   edges come first, each a multiply, then a fixed-interval step or a serial divide.
// Each bucket closed adds a serial division and square root unless its span is empty,
//   a check and a send step, plus a new end edge; one word is in flight at a time.
// Reset (synchronous): registers, position, bucket and sum go to zero.
// ----------------------------------------------------------------------------
// bucketed_rms_envelope_unit: windowed RMS level meter
// Splits a trimmed frame range into buckets and reports the RMS of each.
// ----------------------------------------------------------------------------
module bucketed_rms_envelope_unit import brms_pkg::*; #(
   parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int FRAME_BITS  = DEF_FRAME_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [LEVEL_W-1:0]            rsp_rms_level,
   output logic [NUMBER_W-1:0]           rsp_bucket_number,
   output logic                          rsp_last_bucket
);

   localparam int PROD_W = COUNT_W + INTERVAL_W;
   localparam int SQ_W   = 2 * SAMPLE_BITS;
   localparam int ROOT_W = (SUM_W + 1) / 2;

   // configuration
   logic [FRAME_W-1:0]    total_ff, tstart_ff, tend_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [INTERVAL_W-1:0] interval_ff;

   // effective settings and trimmed range
   logic [FRAME_W-1:0] eff_total, t_minus_end, lo_c, hi_c;
   logic [COUNT_W-1:0] eff_count;

   // sequencer state
   state_type          state_ff, state_in;
   logic [FRAME_W-1:0] fp_ff, fp_in;
   logic [COUNT_W-1:0] cb_ff, cb_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [FRAME_W-1:0] bstart_ff, bstart_in;
   logic [FRAME_W-1:0] bend_ff, bend_in;
   logic               flush_ff, flush_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // per-word working values
   logic [FRAME_W-1:0]     p_ff, p_in;
   logic [SAMPLE_BITS-1:0] mag_ff, mag_in;
   logic [FRAME_W-1:0]     t_ff, t_in;
   logic [COUNT_W-1:0]     n_ff, n_in;
   logic [FRAME_W-1:0]     lo_ff, lo_in;
   logic [FRAME_W-1:0]     hi_ff, hi_in;
   logic [COUNT_W-1:0]     k_ff, k_in;
   logic                   is_end_ff, is_end_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [LEVEL_W-1:0]     level_ff, level_in;
   logic [NUMBER_W-1:0]    number_ff, number_in;
   logic                   last_ff, last_in;

   // helpers
   logic [SAMPLE_BITS-1:0] raw;
   logic [SQ_W-1:0]        square;
   logic [PROD_W-1:0]      rounded;
   logic [FRAME_W:0]       fixed_edge;
   logic [FRAME_W-1:0]     edge_val;
   logic                   edge_ok;
   logic [FRAME_W-1:0]     span;
   logic [COUNT_W:0]       cb_next;
   logic                   in_bucket;
   logic                   emit_now;

   // serial units
   logic               div_start, div_done;
   logic [SUM_W-1:0]   div_dividend, div_quotient;
   logic [FRAME_W-1:0] div_divisor;
   logic               sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]  sqrt_root;

   brms_div #(.DIVIDEND_W(SUM_W), .DIVISOR_W(FRAME_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   brms_sqrt #(.RAD_W(2 * ROOT_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ((2 * ROOT_W)'(div_quotient)),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Total saturates at 2^FRAME_BITS, count at MAX_BUCKETS.
   always_comb begin
      eff_total = (total_ff > (FRAME_W'(1) << FRAME_BITS)) ?
                  (FRAME_W'(1) << FRAME_BITS) : total_ff;
      eff_count = (count_ff > COUNT_W'(MAX_BUCKETS)) ? COUNT_W'(MAX_BUCKETS) : count_ff;
      t_minus_end = eff_total - tend_ff;
      // degenerate trim falls back to the whole buffer
      if (tend_ff >= eff_total || tstart_ff >= t_minus_end) begin
         lo_c = '0;
         hi_c = eff_total;
      end else begin
         lo_c = tstart_ff;
         hi_c = t_minus_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         tstart_ff   <= '0;
         tend_ff     <= '0;
         count_ff    <= '0;
         interval_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TOTAL:      total_ff    <= csr_data[FRAME_W-1:0];
            REG_TRIM_START: tstart_ff   <= csr_data[FRAME_W-1:0];
            REG_TRIM_END:   tend_ff     <= csr_data[FRAME_W-1:0];
            REG_COUNT:      count_ff    <= csr_data[COUNT_W-1:0];
            REG_INTERVAL:   interval_ff <= csr_data[INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      raw    = req_sample;
      square = SQ_W'(mag_ff) * SQ_W'(mag_ff);
      // fixed interval edge: round half up, then clamp to the range end
      rounded    = prod_ff + PROD_W'(32768);
      fixed_edge = {1'b0, lo_ff} + (FRAME_W + 1)'(rounded[PROD_W-1:16]);
      span       = (bend_ff > bstart_ff) ? (bend_ff - bstart_ff) : '0;
      cb_next    = {1'b0, cb_ff} + (COUNT_W + 1)'(1);
      in_bucket  = (cb_ff < n_ff) && (p_ff >= bstart_ff) && (p_ff < bend_ff);
      emit_now   = (cb_ff < n_ff) && (flush_ff || bend_ff <= p_ff);
   end

   always_comb begin
      state_in     = state_ff;
      fp_in        = fp_ff;
      cb_in        = cb_ff;
      sum_in       = sum_ff;
      bstart_in    = bstart_ff;
      bend_in      = bend_ff;
      flush_in     = flush_ff;
      rsp_valid_in = rsp_valid_ff;
      p_in         = p_ff;
      mag_in       = mag_ff;
      t_in         = t_ff;
      n_in         = n_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      k_in         = k_ff;
      is_end_in    = is_end_ff;
      prod_in      = prod_ff;
      level_in     = level_ff;
      number_in    = number_ff;
      last_in      = last_ff;
      div_start    = 1'b0;
      div_dividend = SUM_W'(prod_ff[INTERVAL_W-1:0]);
      div_divisor  = FRAME_W'(n_ff);
      sqrt_start   = 1'b0;
      edge_ok      = 1'b0;
      edge_val     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (eff_total == '0 || eff_count == '0) begin
                  fp_in     = '0;
                  cb_in     = '0;
                  sum_in    = '0;
                  bstart_in = '0;
                  bend_in   = '0;
               end else begin
                  p_in   = fp_ff;
                  mag_in = raw[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - raw) : raw;
                  t_in   = eff_total;
                  n_in   = eff_count;
                  lo_in  = lo_c;
                  hi_in  = hi_c;
                  cb_in  = (cb_ff > eff_count) ? eff_count : cb_ff;
                  if (cb_in < eff_count) begin
                     k_in      = cb_in;
                     is_end_in = 1'b0;
                     state_in  = ST_EDGE_MUL;
                  end else begin
                     state_in = ST_ACC;
                  end
               end
            end
         end

         ST_EDGE_MUL: begin
            if (interval_ff != '0) begin
               prod_in = PROD_W'(k_ff) * PROD_W'(interval_ff);
            end else begin
               prod_in = PROD_W'(k_ff) * PROD_W'(hi_ff - lo_ff);
            end
            state_in = ST_EDGE_RES;
         end

         ST_EDGE_RES: begin
            if (interval_ff != '0) begin
               edge_ok  = 1'b1;
               edge_val = (fixed_edge > {1'b0, hi_ff}) ? hi_ff : fixed_edge[FRAME_W-1:0];
            end else begin
               div_start = 1'b1;
               state_in  = ST_EDGE_DIV;
            end
         end

         ST_EDGE_DIV: begin
            if (div_done) begin
               edge_ok  = 1'b1;
               edge_val = lo_ff + div_quotient[FRAME_W-1:0];
            end
         end

         ST_CHECK: begin
            if (emit_now) begin
               if (span == '0) begin
                  level_in     = '0;
                  number_in    = cb_ff[NUMBER_W-1:0];
                  last_in      = (cb_next == {1'b0, n_ff});
                  sum_in       = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_SEND;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = sum_ff;
                  div_divisor  = span;
                  state_in     = ST_MEAN;
               end
            end else if (!flush_ff) begin
               state_in = ST_ACC;
            end else begin
               // buffer done: rearm for the next one
               fp_in     = '0;
               cb_in     = '0;
               sum_in    = '0;
               bstart_in = '0;
               bend_in   = '0;
               flush_in  = 1'b0;
               state_in  = ST_IDLE;
            end
         end

         ST_MEAN: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               state_in   = ST_ROOT;
            end
         end

         ST_ROOT: begin
            if (sqrt_done) begin
               level_in     = sqrt_root[LEVEL_W-1:0];
               number_in    = cb_ff[NUMBER_W-1:0];
               last_in      = (cb_next == {1'b0, n_ff});
               sum_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_SEND;
            end
         end

         ST_SEND: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               cb_in        = cb_next[COUNT_W-1:0];
               if (cb_next < {1'b0, n_ff}) begin
                  // next bucket starts where this one ended
                  bstart_in = bend_ff;
                  k_in      = COUNT_W'(cb_next + (COUNT_W + 1)'(1));
                  is_end_in = 1'b1;
                  state_in  = ST_EDGE_MUL;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end

         ST_ACC: begin
            if (in_bucket) begin
               sum_in = sum_ff + SUM_W'(square);
            end
            if ({1'b0, p_ff} + (FRAME_W + 1)'(1) >= {1'b0, t_ff}) begin
               flush_in = 1'b1;
               state_in = ST_CHECK;
            end else begin
               fp_in    = p_ff + FRAME_W'(1);
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (edge_ok) begin
         if (!is_end_ff) begin
            bstart_in = edge_val;
            k_in      = k_ff + COUNT_W'(1);
            is_end_in = 1'b1;
            state_in  = ST_EDGE_MUL;
         end else begin
            bend_in  = edge_val;
            state_in = ST_CHECK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fp_ff        <= '0;
         cb_ff        <= '0;
         sum_ff       <= '0;
         bstart_ff    <= '0;
         bend_ff      <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fp_ff        <= fp_in;
         cb_ff        <= cb_in;
         sum_ff       <= sum_in;
         bstart_ff    <= bstart_in;
         bend_ff      <= bend_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      mag_ff    <= mag_in;
      t_ff      <= t_in;
      n_ff      <= n_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      k_ff      <= k_in;
      is_end_ff <= is_end_in;
      prod_ff   <= prod_in;
      level_ff  <= level_in;
      number_ff <= number_in;
      last_ff   <= last_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rms_level     = level_ff;
   assign rsp_bucket_number = number_ff;
   assign rsp_last_bucket   = last_ff;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: bench for the bucketed RMS envelope unit
// Streams audio words through several register settings, predicts each bucket
// level in a scoreboard and checks every result word in order.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [15:0] level;
   logic [5:0]  number;
   logic        last;
} level_word_type;

class rms_scoreboard;
   // register copies
   longint unsigned total, trim_start, trim_end, count, interval;
   // running state of the meter
   longint unsigned position, bucket, square_sum, lo_edge, hi_edge;
   level_word_type  pending[$];
   int              errors;
   int              levels_seen;

   function new();
      total = 0; trim_start = 0; trim_end = 0; count = 0; interval = 0;
      position = 0; bucket = 0; square_sum = 0; lo_edge = 0; hi_edge = 0;
      errors = 0; levels_seen = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
         brms_pkg::REG_TOTAL:      total = data & 32'h1FF_FFFF;
         brms_pkg::REG_TRIM_START: trim_start = data & 32'h1FF_FFFF;
         brms_pkg::REG_TRIM_END:   trim_end = data & 32'h1FF_FFFF;
         brms_pkg::REG_COUNT:      count = data & 32'h7F;
         brms_pkg::REG_INTERVAL:   interval = data;
         default: ;
      endcase
   endfunction

   function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res;
   endfunction

   function longint unsigned bucket_edge(longint unsigned k, longint unsigned lo,
                                         longint unsigned hi, longint unsigned n);
      longint unsigned e;
      if (interval != 0) begin
         e = lo + ((k * interval + 32768) >> 16);
         if (e > hi) e = hi;
      end else begin
         e = lo + (k * (hi - lo)) / n;
      end
      return e;
   endfunction

   function void close_bucket(longint unsigned n);
      level_word_type  w;
      longint unsigned span;
      span = (hi_edge > lo_edge) ? hi_edge - lo_edge : 0;
      w.level  = span ? 16'(int_sqrt(square_sum / span)) : 16'd0;
      w.number = 6'(bucket);
      w.last   = (bucket + 1 == n);
      pending.insert(pending.size(), w);
      square_sum = 0;
      bucket++;
   endfunction

   // accepted sample: advance the meter and queue the levels it closes
   function void note_sample(logic signed [15:0] s);
      longint unsigned t, n, lo, hi, p, mag;
      logic [15:0]     raw;
      t = (total > (64'd1 << 24)) ? (64'd1 << 24) : total;
      n = (count > 64) ? 64 : count;
      if (t == 0 || n == 0) begin
         position = 0; bucket = 0; square_sum = 0; lo_edge = 0; hi_edge = 0;
         return;
      end
      // degenerate trim falls back to the full buffer
      if (trim_end >= t || trim_start >= t - trim_end) begin
         lo = 0; hi = t;
      end else begin
         lo = trim_start; hi = t - trim_end;
      end
      p = position;
      if (bucket > n) bucket = n;
      raw = s;
      mag = s[15] ? 65536 - raw : raw;
      if (bucket < n) begin
         lo_edge = bucket_edge(bucket, lo, hi, n);
         hi_edge = bucket_edge(bucket + 1, lo, hi, n);
      end
      while (bucket < n && hi_edge <= p) begin
         close_bucket(n);
         if (bucket < n) begin
            lo_edge = bucket_edge(bucket, lo, hi, n);
            hi_edge = bucket_edge(bucket + 1, lo, hi, n);
         end
      end
      if (bucket < n && p >= lo_edge && p < hi_edge)
         square_sum = (square_sum + mag * mag) & ((64'd1 << 55) - 1);
      if (p + 1 >= t) begin
         // last frame flushes everything and rearms
         while (bucket < n) begin
            close_bucket(n);
            if (bucket < n) begin
               lo_edge = bucket_edge(bucket, lo, hi, n);
               hi_edge = bucket_edge(bucket + 1, lo, hi, n);
            end
         end
         position = 0; bucket = 0; square_sum = 0; lo_edge = 0; hi_edge = 0;
      end else begin
         position = (p + 1) & 64'h1FF_FFFF;
      end
   endfunction

   function void check_level(logic [15:0] level, logic [5:0] number, logic last);
      level_word_type w;
      if (pending.size() == 0) begin
         $error("unexpected level word: level %0d bucket %0d", level, number);
         errors++;
         return;
      end
      w = pending.pop_front();
      levels_seen++;
      if (level !== w.level) begin
         $error("rms_level: expected %0d, got %0d", w.level, level);
         errors++;
      end
      if (number !== w.number) begin
         $error("bucket_number: expected %0d, got %0d", w.number, number);
         errors++;
      end
      if (last !== w.last) begin
         $error("last_bucket: expected %0d, got %0d", w.last, last);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import brms_pkg::*;

   localparam int IDLE_LIMIT  = 20000;  // cycles with no accept while work is open
   localparam int SETTLE_WAIT = 250;    // covers two even-division edges

   logic                    clock;
   logic                    reset;
   logic                    csr_write;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [15:0]      req_sample;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [LEVEL_W-1:0]      rsp_rms_level;
   logic [NUMBER_W-1:0]     rsp_bucket_number;
   logic                    rsp_last_bucket;

   rms_scoreboard meter = new();
   int            words_sent;
   int            phases_run;
   int            idle_cycles = 0;

   bucketed_rms_envelope_unit DUT (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_rms_level(rsp_rms_level), .rsp_bucket_number(rsp_bucket_number),
      .rsp_last_bucket(rsp_last_bucket)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: only counts while a word is offered or a level is owed.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (req_valid || meter.pending.size() != 0)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side: random stall before each word, sometimes long runs of none.
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
         if (n > 0) begin
            @(negedge clock) rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end
         @(negedge clock) rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         meter.check_level(rsp_rms_level, rsp_bucket_number, rsp_last_bucket);
      end
   end

   // Register write; any word still offered is withdrawn first.
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      meter.write_reg(idx, data);
      @(negedge clock) csr_write <= 1'b0;
   endtask

   task automatic setup(logic [31:0] tot, logic [31:0] ts, logic [31:0] te,
                        logic [31:0] cnt, logic [31:0] iv);
      write_reg(REG_TOTAL, tot);
      write_reg(REG_TRIM_START, ts);
      write_reg(REG_TRIM_END, te);
      write_reg(REG_COUNT, cnt);
      write_reg(REG_INTERVAL, iv);
      phases_run++;
   endtask

   // Send one word; valid stays up across back-to-back words.
   task automatic send_word(logic signed [15:0] s);
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      meter.note_sample(s);
      words_sent++;
   endtask

   // Block must be quiet before a register write: no level owed, and time
   // for a word that closes nothing to finish its edge math.
   task automatic drain();
      @(negedge clock) req_valid <= 1'b0;
      while (meter.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'(signed'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_total();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 32'h100_0000;
         2: return 32'h1FF_FFFF;
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   initial begin
      logic signed [15:0] directed[8] = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1,
                                          16'sd1, 16'sh8000, 16'sh7FFF, 16'sh5555};
      logic [31:0] tot, ts, te, cnt, iv;
      int          items;

      reset       = 1'b1;
      csr_write   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      req_valid   = 1'b0;
      req_sample  = '0;
      words_sent  = 0;
      phases_run  = 0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // even division, extreme samples, one full buffer
      setup(8, 0, 0, 4, 0);
      foreach (directed[i]) send_word(directed[i]);
      drain();
      // fixed 1.5-frame interval with trim; last buckets clamp to the end
      setup(6, 1, 1, 5, 32'h0001_8000);
      repeat (6) send_word(rand_sample());
      drain();
      // degenerate trim falls back to the whole buffer, count saturates
      setup(5, 7, 2, 127, 0);
      repeat (5) send_word(rand_sample());
      drain();
      // no work: zero buckets, then zero frames
      setup(4, 0, 0, 0, 0);
      repeat (2) send_word(rand_sample());
      setup(0, 0, 0, 5, 32'hFFFF_FFFF);
      repeat (2) send_word(rand_sample());
      drain();

      // random settings; phases are not buffer aligned so a shrinking buffer
      // lands the position past its end now and then
      while (words_sent < 360) begin
         tot = pick_total();
         ts  = ($urandom_range(0, 7) == 0) ? 32'h1FF_FFFF : $urandom_range(0, 12);
         te  = ($urandom_range(0, 7) == 0) ? 32'h1FF_FFFF : $urandom_range(0, 12);
         case ($urandom_range(0, 5))
            0: cnt = 64;
            1: cnt = $urandom_range(65, 127);
            2: cnt = $urandom_range(0, 1);
            default: cnt = $urandom_range(1, 12);
         endcase
         case ($urandom_range(0, 4))
            0: iv = 0;
            1: iv = 32'hFFFF_FFFF;
            2: iv = $urandom;
            default: iv = $urandom_range(0, 32'h0006_0000);
         endcase
         setup(tot, ts, te, cnt, iv);
         items = (tot != 0 && tot <= 40) ? 2 * tot + $urandom_range(0, 3) : 20;
         repeat (items) send_word(rand_sample());
         // sender holds off mid-phase until the meter has caught up
         if (phases_run == 8) begin
            @(negedge clock) req_valid <= 1'b0;
            while (meter.pending.size() != 0) @(posedge clock);
            repeat (4) send_word(rand_sample());
         end
         drain();
      end

      $display("covered %0d sample words over %0d register settings, %0d levels checked",
               words_sent, phases_run, meter.levels_seen);
      $display("settings spanned empty, saturated and degenerate-trim buffers, both split modes");
      if (meter.errors == 0 && meter.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
